@@ hdl/sha256_pkg.sv @@
// shared types, constants and functions for the sha-256 byte stream hasher
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int BLOCK_LEN = 64;
    localparam int LEN_OFFSET = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // datapath byte source select
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      put_byte;     // write one byte into the block
        byte_src_t src;
        logic      count_bits;   // add 8 to the bit count
        logic      latch_len;    // snapshot bit count for the length field
        logic      comp_start;   // load working vars from the hash
        logic      comp_round;   // run one round
        logic      comp_finish;  // add working vars into the hash
        logic      out_load;     // present digest word
        logic      msg_reset;    // back to initial hash, zero counts
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;        // bytes held in the block
        logic       fill_full;   // 64 bytes held
        logic [5:0] round;
        logic [2:0] len_idx;
    } dp_status_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ hdl/sha256_datapath.sv @@
// sha-256 datapath: block buffer, message schedule, round unit, hash state
`timescale 1ns / 1ps
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  in_byte,
    input  logic [2:0]  out_idx,
    output dp_status_t  status,
    output word_t       out_word
);

    word_t       hash_reg [8];
    word_t       wv_reg [8];
    word_t       sched_reg [16];   // 16-word sliding message schedule
    logic [6:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [2:0]  len_idx_reg;
    word_t       out_reg;

    logic [7:0]  byte_mux;
    word_t       w_next, s0, s1, big0, big1, ch, maj, t1, t2;
    logic [3:0]  widx;
    logic [4:0]  wsh;

    always_comb
    begin
        case (cmd.src)
            SRC_DATA: byte_mux = in_byte;
            SRC_PAD:  byte_mux = PAD_MARK;
            SRC_ZERO: byte_mux = 8'h00;
            default:  byte_mux = len_reg[63 - 8 * len_idx_reg -: 8];
        endcase
    end

    assign widx = fill_reg[5:2];
    assign wsh  = 5'((3 - fill_reg[1:0]) * 8);

    always_comb
    begin
        s0 = rotr(sched_reg[1], 7) ^ rotr(sched_reg[1], 18) ^ (sched_reg[1] >> 3);
        s1 = rotr(sched_reg[14], 17) ^ rotr(sched_reg[14], 19) ^ (sched_reg[14] >> 10);
        w_next = s1 + sched_reg[9] + s0 + sched_reg[0];
        big1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
        ch   = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        t1   = wv_reg[7] + big1 + ch + ROUND_K[round_reg] + sched_reg[0];
        big0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
        maj  = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t2   = big0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
            end
            fill_reg    <= '0;
            round_reg   <= '0;
            bits_reg    <= '0;
            len_idx_reg <= '0;
        end
        else
        begin
            if (cmd.count_bits)
            begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.put_byte)
            begin
                fill_reg <= fill_reg + 7'd1;
                if (cmd.src == SRC_LEN)
                begin
                    len_idx_reg <= len_idx_reg + 3'd1;
                end
            end
            if (cmd.comp_round)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.comp_finish)
            begin
                fill_reg  <= '0;
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end
            if (cmd.msg_reset)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= INIT_HASH[i];
                end
                fill_reg    <= '0;
                bits_reg    <= '0;
                len_idx_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_len)
        begin
            len_reg <= bits_reg;
        end
        if (cmd.put_byte)
        begin
            if (fill_reg[1:0] == 2'd0)
            begin
                sched_reg[widx] <= word_t'(byte_mux) << wsh;
            end
            else
            begin
                sched_reg[widx] <= sched_reg[widx] | (word_t'(byte_mux) << wsh);
            end
        end
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                wv_reg[i] <= hash_reg[i];
            end
        end
        if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_next;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
        if (cmd.out_load)
        begin
            out_reg <= hash_reg[out_idx];
        end
    end

    assign status.fill      = fill_reg[5:0];
    assign status.fill_full = fill_reg[6];
    assign status.round     = round_reg;
    assign status.len_idx   = len_idx_reg;
    assign out_word         = out_reg;

endmodule

@@ hdl/sha256_ctrl.sv @@
// sha-256 control state machine: accept, padding, rounds, digest output
`timescale 1ns / 1ps
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_byte_valid,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_last,
    output logic [2:0]  out_idx,
    output dp_cmd_t     cmd,
    input  dp_status_t  status
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_ROUND = 8'b00000010,
        ST_PAD   = 8'b00000100,
        ST_ZERO  = 8'b00001000,
        ST_LEN   = 8'b00010000,
        ST_FIN   = 8'b00100000,
        ST_ADD   = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    state_t     resume_reg, resume_next;   // where to go after the hash add
    logic       ov_reg, ov_next;
    logic [2:0] idx_reg, idx_next;
    logic [3:0] sent_reg, sent_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign out_last  = (sent_reg == 4'd7);
    assign out_idx   = idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        ov_next     = ov_reg;
        idx_next    = idx_reg;
        sent_next   = sent_reg;
        cmd         = '0;
        cmd.src     = SRC_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_len = 1'b1;
                    if (in_byte_valid)
                    begin
                        cmd.put_byte   = 1'b1;
                        cmd.count_bits = 1'b1;
                    end
                    if (in_byte_valid && status.fill == 6'd63)
                    begin
                        // block full: pad after compressing if this was the last beat
                        state_next  = ST_FIN;
                        resume_next = in_last ? ST_PAD : ST_IDLE;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // snapshot again so a byte taken with the last marker is counted
                cmd.latch_len = 1'b1;
                cmd.put_byte  = 1'b1;
                cmd.src       = SRC_PAD;
                if (status.fill == 6'd63)
                begin
                    state_next  = ST_FIN;
                    resume_next = ST_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (status.fill_full)
                begin
                    state_next = ST_FIN;
                end
                else if (status.fill == 6'(LEN_OFFSET))
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.put_byte = 1'b1;
                    cmd.src      = SRC_ZERO;
                    if (status.fill == 6'd63)
                    begin
                        // no room for the length: zero-fill one more block
                        state_next  = ST_FIN;
                        resume_next = ST_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.put_byte = 1'b1;
                cmd.src      = SRC_LEN;
                if (status.len_idx == 3'd7)
                begin
                    state_next  = ST_FIN;
                    resume_next = ST_OUT;
                end
            end
            ST_FIN:
            begin
                // block full: load working vars
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (status.round == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.comp_finish = 1'b1;
                state_next      = resume_reg;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    idx_next     = 3'd1;
                end
                else if (out_ready)
                begin
                    if (sent_reg == 4'd7)
                    begin
                        ov_next       = 1'b0;
                        sent_next     = 4'd0;
                        idx_next      = 3'd0;
                        cmd.msg_reset = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        sent_next    = sent_reg + 4'd1;
                        idx_next     = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            ov_reg     <= 1'b0;
            idx_reg    <= '0;
            sent_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            ov_reg     <= ov_next;
            idx_reg    <= idx_next;
            sent_reg   <= sent_next;
        end
    end

endmodule

@@ hdl/sha256_byte_stream_hasher.sv @@
// top level of the sha-256 byte stream hasher
//   channel | dir | tdata                  | tuser            | tlast
//   s_axis  | in  | data_byte[7:0]         | byte_valid       | last_byte
//   m_axis  | out | digest_word[31:0]      | -                | digest_last
// one byte beat per cycle while a block fills; a full block then passes
// through the round unit (load, 64 rounds one per cycle, hash add).
// a last beat adds padding one byte per cycle and one or two compressions,
// then eight digest beats; out stalls hold the state machine.
// reset (rst_n low, async) restores the initial hash and clears all counts.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // digest_last
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] out_idx;

    sha256_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_byte_valid (s_axis_tuser),
        .in_last       (s_axis_tlast),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_last      (m_axis_tlast),
        .out_idx       (out_idx),
        .cmd           (cmd),
        .status        (status)
    );

    sha256_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (s_axis_tdata),
        .out_idx  (out_idx),
        .status   (status),
        .out_word (m_axis_tdata)
    );

endmodule

@@ tb/sv/tb_sha256_byte_stream_hasher.sv @@
// testbench for the sha-256 byte stream hasher: directed and random messages checked against a digest predictor
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher
    import sha256_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // data_byte
    logic        s_axis_tuser;    // byte_valid
    logic        s_axis_tlast;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // digest_word
    logic        m_axis_tlast;    // digest_last

    int  error_count;
    bit  hold_off_req;
    int  hold_off_cycles;

    sha256_byte_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    class digest_scoreboard;
        word_t        hash_st [8];
        word_t        blk [16];
        int           fill;
        logic [63:0]  msg_bits;
        digest_beat_t pending [$];

        function new();
            foreach (hash_st[i]) hash_st[i] = INIT_HASH[i];
            fill = 0;
            msg_bits = '0;
        endfunction

        function word_t ror(word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            word_t w [64];
            word_t v [8];
            word_t t1, t2;
            for (int t = 0; t < 16; t++) w[t] = blk[t];
            for (int t = 16; t < 64; t++)
                w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            foreach (v[i]) v[i] = hash_st[i];
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (v[i]) hash_st[i] += v[i];
        endfunction

        function void add_byte(logic [7:0] b);
            if (fill % 4 == 0) blk[fill / 4] = '0;
            blk[fill / 4][(3 - fill % 4) * 8 +: 8] = b;
            fill++;
            if (fill == BLOCK_LEN)
            begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_input(logic [7:0] data, logic valid, logic last);
            logic [63:0] len;
            if (valid)
            begin
                msg_bits += 64'd8;
                add_byte(data);
            end
            if (!last) return;
            len = msg_bits;
            add_byte(PAD_MARK);
            while (fill != LEN_OFFSET) add_byte(8'h00);
            for (int k = 0; k < 8; k++) add_byte(len[56 - 8 * k +: 8]);
            for (int k = 0; k < 8; k++) pending.push_back({hash_st[k], 1'(k == 7)});
            foreach (hash_st[i]) hash_st[i] = INIT_HASH[i];
            fill = 0;
            msg_bits = '0;
        endfunction

        task check_result(logic [31:0] word, logic last);
            digest_beat_t exp_b;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digest beat %h", word));
                return;
            end
            exp_b = pending.pop_front();
            if (word !== exp_b.word)
                report_mismatch($sformatf("digest word %h, predicted %h", word, exp_b.word));
            if (last !== exp_b.last)
                report_mismatch($sformatf("tlast %b, predicted %b", last, exp_b.last));
        endtask
    endclass

    digest_scoreboard sb;

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sender burst state
    int burst_left;
    int gap_left;

    // send one beat; bursts with random gaps
    task automatic send_beat(input logic [7:0] d, input logic v, input logic l);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= v;
        s_axis_tlast  <= l;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(d, v, l);
        burst_left--;
    endtask

    task automatic send_message(input int len, input bit empty_end, input int fixed);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);  // ignored beat
            send_beat((fixed >= 0) ? 8'(fixed) : 8'($urandom), 1'b1,
                      (!empty_end && i == len - 1));
        end
        if (empty_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // receiver: stall pattern plus requested long hold-off
    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_off_req)
            begin
                hold_off_cycles++;
                m_axis_tready <= 1'b0;
                if (hold_off_cycles >= 600) hold_off_req = 1'b0;
            end
            else
            begin
                phase++;
                if ((phase / 200) % 2 == 0) m_axis_tready <= 1'b1;
                else m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        error_count = 0;
        hold_off_req = 1'b0;
        hold_off_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, single bytes, short messages
        send_message(0, 1'b1, -1);
        send_message(1, 1'b0, 8'h00);
        send_message(1, 1'b0, 8'hff);
        send_message(3, 1'b1, 8'h55);
        send_message(2, 1'b0, 8'haa);
        drain();
        // receiver holds off, so the waiting digest stalls the input; padding spills into a second block
        hold_off_req = 1'b1;
        send_message(56, 1'b1, -1);
        send_message($urandom_range(0, 6), 1'b0, -1);
        send_message($urandom_range(0, 6), 1'b1, -1);
        drain();
        // last byte fills a block, then a block boundary inside a message
        send_message(64, 1'b0, -1);
        send_message(65, 1'b0, -1);
        drain();
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
